### rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Shared types and byte codes for the parser front end, job queue and
// result sequencer.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  // Byte classes.
  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSCOM_MIN   = 8'hF0;

  // High nibbles of channel status bytes.
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CTRL      = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;

  // Result kinds.
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_THRU  = 1'b1;

  // Job queue between front end and sequencer.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // One completed message: the event plus how its thru bytes look.
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic       thru_hdr;    // emit the status (or real-time) byte as thru
    logic [1:0] thru_ndata;  // thru data bytes that follow, 0 to 2
  } job_t;

endpackage

### rtl/mrsp_front.sv
// ----------------------------------------------------------------------------
// MIDI parser front end
// Tracks running status per stream, pairs data bytes and decides the thru
// encoding of each completed message, then hands a job to the queue.
// ----------------------------------------------------------------------------
module mrsp_front #(
  parameter int STREAMS  = 2,
  parameter int TX_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic            stream,
  input  logic [6:0]      tx_free,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  output logic            push,
  output mrsp_pkg::job_t  push_job
);

  localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam bit MULTI = (STREAMS > 1);

  logic [7:0] rs_r [STREAMS];
  logic       hf_r [STREAMS];
  logic [6:0] fd_r [STREAMS];
  logic [7:0] txrs_r;
  logic       thru_dis_r;

  logic [SW-1:0] idx;
  logic          stream_ok;
  logic          go;
  logic [7:0]    rs;
  logic [3:0]    hi;
  logic          one_data;
  logic          two_data;
  logic          q_empty;
  logic [1:0]    need;
  logic          room;

  logic          set_rs;
  logic [7:0]    rs_nxt;
  logic          set_hf;
  logic          hf_nxt;
  logic          set_fd;
  logic          set_txrs;

  assign idx       = SW'(stream);
  assign stream_ok = MULTI || (stream == 1'b0);
  assign go        = accept && stream_ok;
  assign rs        = rs_r[idx];
  assign hi        = rs[7:4];
  assign q_empty   = {2'b00, tx_free} >= 9'(TX_DEPTH);

  always_comb begin
    one_data = 1'b0;
    two_data = 1'b0;
    case (hi)
      mrsp_pkg::HI_PROGRAM, mrsp_pkg::HI_CHAN_PRES: one_data = 1'b1;
      mrsp_pkg::HI_NOTE_OFF, mrsp_pkg::HI_NOTE_ON, mrsp_pkg::HI_POLY_AT,
      mrsp_pkg::HI_CTRL, mrsp_pkg::HI_PITCH: two_data = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    push                 = 1'b0;
    push_job.status      = rs;
    push_job.data_first  = 7'd0;
    push_job.data_second = 7'd0;
    push_job.thru_hdr    = 1'b0;
    push_job.thru_ndata  = 2'd0;
    need                 = 2'd1;
    set_rs               = 1'b0;
    rs_nxt               = 8'd0;
    set_hf               = 1'b0;
    hf_nxt               = 1'b0;
    set_fd               = 1'b0;
    set_txrs             = 1'b0;

    if (rx_byte[7]) begin
      if (rx_byte >= mrsp_pkg::REALTIME_MIN) begin
        push            = 1'b1;
        push_job.status = rx_byte;
        need            = 2'd1;
      end else begin
        // Channel status starts a new running status; system common clears it.
        set_rs = 1'b1;
        set_hf = 1'b1;
        rs_nxt = (rx_byte < mrsp_pkg::SYSCOM_MIN) ? rx_byte : 8'd0;
      end
    end else if (!hf_r[idx]) begin
      if (one_data) begin
        push                = 1'b1;
        push_job.data_first = rx_byte[6:0];
        need                = 2'd2;
      end else begin
        set_fd = 1'b1;
        set_hf = 1'b1;
        hf_nxt = 1'b1;
      end
    end else begin
      set_hf = 1'b1;
      if (two_data) begin
        push                 = 1'b1;
        push_job.data_first  = fd_r[idx];
        push_job.data_second = rx_byte[6:0];
        need                 = 2'd3;
      end
    end

    // The status slot is counted even when running status omits it.
    room = !thru_dis_r && ({5'd0, need} <= tx_free);
    if (room) begin
      if (need == 2'd1) begin
        push_job.thru_hdr = 1'b1;
      end else begin
        push_job.thru_hdr   = q_empty || (txrs_r != rs);
        push_job.thru_ndata = need - 2'd1;
        set_txrs            = push_job.thru_hdr;
      end
    end
    push = push && go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STREAMS; i++) begin
        rs_r[i] <= 8'd0;
        hf_r[i] <= 1'b0;
      end
      txrs_r     <= 8'd0;
      thru_dis_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thru_dis_r <= cfg_wr_data;
      end
      if (go) begin
        if (set_rs) begin
          rs_r[idx] <= rs_nxt;
        end
        if (set_hf) begin
          hf_r[idx] <= hf_nxt;
        end
        if (set_fd) begin
          fd_r[idx] <= rx_byte[6:0];
        end
        if (push && set_txrs) begin
          txrs_r <= rs;
        end
      end
    end
  end

endmodule

### rtl/mrsp_queue.sv
// ----------------------------------------------------------------------------
// MIDI parser job queue
// Short FIFO of completed messages between the front end and the sequencer.
// ----------------------------------------------------------------------------
module mrsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrsp_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output mrsp_pkg::job_t  head
);

  mrsp_pkg::job_t             mem_r [mrsp_pkg::Q_DEPTH];
  logic [mrsp_pkg::Q_AW-1:0]  wp_r;
  logic [mrsp_pkg::Q_AW-1:0]  rp_r;
  logic [mrsp_pkg::Q_AW:0]    cnt_r;
  logic [mrsp_pkg::Q_AW:0]    cnt_nxt;

  assign full      = (cnt_r == (mrsp_pkg::Q_AW + 1)'(mrsp_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == mrsp_pkg::Q_AW'(mrsp_pkg::Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == mrsp_pkg::Q_AW'(mrsp_pkg::Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

### rtl/mrsp_back.sv
// ----------------------------------------------------------------------------
// MIDI parser result sequencer
// Expands each queued job into its event and thru results, one per cycle while
// out_stall is low, into a registered output stage.
// ----------------------------------------------------------------------------
module mrsp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  mrsp_pkg::job_t  job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_kind,
  output logic [7:0]      out_status,
  output logic [6:0]      out_data_first,
  output logic [6:0]      out_data_second,
  output logic [7:0]      out_thru_byte,
  output logic            out_last
);

  logic [1:0] pos_r;
  logic       valid_r;
  logic       kind_r;
  logic [7:0] status_r;
  logic [6:0] d0_r;
  logic [6:0] d1_r;
  logic [7:0] tb_r;
  logic       last_r;

  logic       load;
  logic [2:0] total;
  logic       last;
  logic [1:0] q;
  logic [1:0] didx;
  logic [7:0] tbyte;

  assign load  = job_valid && (!valid_r || !out_stall);
  assign total = 3'd1 + {2'b00, job.thru_hdr} + {1'b0, job.thru_ndata};
  assign last  = ({1'b0, pos_r} + 3'd1) == total;
  assign pop   = load && last;

  // Position zero is the event; the thru bytes follow it.
  always_comb begin
    q     = pos_r - 2'd1;
    didx  = job.thru_hdr ? q - 2'd1 : q;
    if (job.thru_hdr && q == 2'd0) begin
      tbyte = job.status;
    end else if (didx == 2'd0) begin
      tbyte = {1'b0, job.data_first};
    end else begin
      tbyte = {1'b0, job.data_second};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r   <= last ? 2'd0 : pos_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= last;
      if (pos_r == 2'd0) begin
        kind_r   <= mrsp_pkg::KIND_EVENT;
        status_r <= job.status;
        d0_r     <= job.data_first;
        d1_r     <= job.data_second;
        tb_r     <= 8'd0;
      end else begin
        kind_r   <= mrsp_pkg::KIND_THRU;
        status_r <= 8'd0;
        d0_r     <= 7'd0;
        d1_r     <= 7'd0;
        tb_r     <= tbyte;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_status      = status_r;
  assign out_data_first  = d0_r;
  assign out_data_second = d1_r;
  assign out_thru_byte   = tb_r;
  assign out_last        = last_r;

endmodule

### rtl/midi_running_status_parser_thru_core.sv
// ----------------------------------------------------------------------------
// MIDI running status parser with thru
// Parses MIDI bytes from several streams into message events and re-encodes
// them as thru bytes with a shared transmit running status.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall   rx_byte, stream, tx_free
//   out_     output     out_valid / out_stall kind, status, data, thru byte, last
//   cfg_     input      cfg_wr_en             cfg_wr_data (thru disable)
//
// A byte is taken every cycle while the job queue has room; it produces up
// to four results, delivered one per cycle by the sequencer while out_stall
// is low; a byte that completes no message yields none. The first result of a
// byte is registered in the job queue and then in the sequencer output stage.
// Reset is synchronous and clears all running status and the thru setting.
// out_stall holds the output register; input stalls only once the job queue
// is full.
// ----------------------------------------------------------------------------
module midi_running_status_parser_thru_core #(
  parameter int STREAMS  = 2,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_stream,
  input  logic [6:0] in_tx_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_status,
  output logic [6:0] out_data_first,
  output logic [6:0] out_data_second,
  output logic [7:0] out_thru_byte,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic           q_full;
  logic           q_not_empty;
  logic           push;
  logic           pop;
  mrsp_pkg::job_t push_job;
  mrsp_pkg::job_t head;

  assign in_stall = q_full;

  mrsp_front #(
    .STREAMS  (STREAMS),
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_valid && !q_full),
    .rx_byte     (in_rx_byte),
    .stream      (in_stream),
    .tx_free     (in_tx_free),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .push_job    (push_job)
  );

  mrsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  mrsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_not_empty),
    .job             (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_data_first  (out_data_first),
    .out_data_second (out_data_second),
    .out_thru_byte   (out_thru_byte),
    .out_last        (out_last)
  );

endmodule

### rtl/mrsp_checker.sv
// ----------------------------------------------------------------------------
// MIDI parser port checker
// Watches the result port of the parser core over time.
// ----------------------------------------------------------------------------
module mrsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_status,
  input logic [6:0] out_data_first,
  input logic [6:0] out_data_second,
  input logic [7:0] out_thru_byte,
  input logic       out_last
);

  // Set when the next delivered item must open a new message.
  logic expect_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_event_r <= 1'b1;
    end else if (out_valid && !out_stall) begin
      expect_event_r <= out_last;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_thru_byte) && $stable(out_last))
    else $error("output item changed while stalled");

  a_event_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expect_event_r |-> out_kind == mrsp_pkg::KIND_EVENT)
    else $error("thru byte delivered before its event");

  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mrsp_pkg::KIND_EVENT |-> out_status[7] && out_thru_byte == 8'd0)
    else $error("event item without a status byte");

  a_thru_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mrsp_pkg::KIND_THRU |->
      out_status == 8'd0 && out_data_first == 7'd0 && out_data_second == 7'd0)
    else $error("thru item carries event fields");

endmodule

bind midi_running_status_parser_thru_core mrsp_checker u_mrsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_status      (out_status),
  .out_data_first  (out_data_first),
  .out_data_second (out_data_second),
  .out_thru_byte   (out_thru_byte),
  .out_last        (out_last)
);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// MIDI running status parser with thru: testbench
// Drives MIDI bytes from two streams through the valid/stall input port,
// predicts the events and thru bytes that each byte causes, and checks every
// result field by field. A directed table comes first, then random message
// sequences under both thru settings, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STREAM_COUNT   = 2;
  localparam int TX_SLOTS       = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_ITEMS   = 140;
  localparam int PHASES         = 4;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_SILENT,
    ROW_EVENT
  } row_check_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] status;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [7:0] thru_byte;
    logic       last;
  } midi_result_t;

  typedef struct {
    logic [7:0] midi;
    logic       strm;
    logic [6:0] free;
    row_check_t check;
    logic [7:0] st;
    logic [6:0] d0;
    logic [6:0] d1;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = '0;
  logic       in_stream = 1'b0;
  logic [6:0] in_tx_free = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_status;
  logic [6:0] out_data_first;
  logic [6:0] out_data_second;
  logic [7:0] out_thru_byte;
  logic       out_last;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  // Typed expectations travel with the item so they are sampled with it.
  row_check_t row_check = ROW_PREDICTED;
  logic [7:0] row_status = '0;
  logic [6:0] row_d0 = '0;
  logic [6:0] row_d1 = '0;

  // Parser state as the block should hold it.
  logic [7:0] run_status [STREAM_COUNT];
  logic       held      [STREAM_COUNT];
  logic [6:0] held_data [STREAM_COUNT];
  logic [7:0] tx_status;
  logic       thru_off;

  midi_result_t step_res [4];
  int           step_n;
  midi_result_t expected_q [$];

  int mismatches = 0;
  int bytes_sent = 0;
  int events_seen = 0;
  int thru_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_run = 0;

  directed_row_t directed_rows [28] = '{
    '{8'hF8, 1'b0, 7'd64,  ROW_EVENT,  8'hF8, 7'h00, 7'h00},
    '{8'hFF, 1'b1, 7'd0,   ROW_EVENT,  8'hFF, 7'h00, 7'h00},
    '{8'h00, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h7F, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h90, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h3C, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'hA1, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h7F, 1'b0, 7'd64,  ROW_EVENT,  8'h90, 7'h3C, 7'h7F},
    '{8'h10, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h00, 1'b0, 7'd3,   ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h20, 1'b1, 7'd3,   ROW_EVENT,  8'hA1, 7'h10, 7'h20},
    '{8'h00, 1'b0, 7'd3,   ROW_EVENT,  8'h90, 7'h00, 7'h00},
    '{8'hC5, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h7F, 1'b1, 7'd1,   ROW_EVENT,  8'hC5, 7'h7F, 7'h00},
    '{8'h12, 1'b1, 7'd64,  ROW_EVENT,  8'hC5, 7'h12, 7'h00},
    '{8'hDF, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h40, 1'b0, 7'd2,   ROW_PREDICTED, 8'h00, 7'h00, 7'h00},
    '{8'hE3, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h01, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'hFC, 1'b1, 7'd10,  ROW_EVENT,  8'hFC, 7'h00, 7'h00},
    '{8'h7E, 1'b1, 7'd10,  ROW_PREDICTED, 8'h00, 7'h00, 7'h00},
    '{8'hF0, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h80, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h11, 1'b0, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h22, 1'b0, 7'd127, ROW_EVENT,  8'h80, 7'h11, 7'h22},
    '{8'hB4, 1'b1, 7'd64,  ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h07, 1'b1, 7'd2,   ROW_SILENT, 8'h00, 7'h00, 7'h00},
    '{8'h64, 1'b1, 7'd2,   ROW_EVENT,  8'hB4, 7'h07, 7'h64}
  };

  midi_running_status_parser_thru_core #(
    .STREAMS (STREAM_COUNT),
    .TX_DEPTH(TX_SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .in_stream      (in_stream),
    .in_tx_free     (in_tx_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_data_first (out_data_first),
    .out_data_second(out_data_second),
    .out_thru_byte  (out_thru_byte),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic midi_result_t event_res(input logic [7:0] st, input logic [6:0] d0,
                                             input logic [6:0] d1);
    midi_result_t r;
    r = '0;
    r.kind = mrsp_pkg::KIND_EVENT;
    r.status = st;
    r.data_first = d0;
    r.data_second = d1;
    return r;
  endfunction

  function automatic midi_result_t thru_res(input logic [7:0] tb);
    midi_result_t r;
    r = '0;
    r.kind = mrsp_pkg::KIND_THRU;
    r.thru_byte = tb;
    return r;
  endfunction

  // Appends the thru bytes of one message, using the shared transmit running
  // status. The status slot counts toward the room even when it is left out.
  task automatic add_thru(input int nbytes, input logic [7:0] st, input logic [6:0] d0,
                          input logic [6:0] d1, input logic [6:0] free);
    logic empty;
    empty = (free >= TX_SLOTS);
    if (thru_off || free < nbytes) return;
    if (nbytes == 1) begin
      step_res[step_n] = thru_res(st);
      step_n++;
      return;
    end
    if (empty || tx_status != st) begin
      step_res[step_n] = thru_res(st);
      step_n++;
      tx_status = st;
    end
    step_res[step_n] = thru_res({1'b0, d0});
    step_n++;
    if (nbytes > 2) begin
      step_res[step_n] = thru_res({1'b0, d1});
      step_n++;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic s, input logic [6:0] free);
    logic [3:0] hi;
    step_n = 0;
    hi = run_status[s][7:4];
    if (b[7]) begin
      if (b >= mrsp_pkg::REALTIME_MIN) begin
        step_res[0] = event_res(b, '0, '0);
        step_n = 1;
        add_thru(1, b, '0, '0, free);
      end else if (b < mrsp_pkg::SYSCOM_MIN) begin
        run_status[s] = b;
        held[s] = 1'b0;
      end else begin
        run_status[s] = '0;
        held[s] = 1'b0;
      end
    end else if (!held[s]) begin
      if (hi == mrsp_pkg::HI_PROGRAM || hi == mrsp_pkg::HI_CHAN_PRES) begin
        step_res[0] = event_res(run_status[s], b[6:0], '0);
        step_n = 1;
        add_thru(2, run_status[s], b[6:0], '0, free);
      end else begin
        held_data[s] = b[6:0];
        held[s] = 1'b1;
      end
    end else begin
      // A completed pair with no two-byte status (zero or otherwise) is lost.
      held[s] = 1'b0;
      if (hi == mrsp_pkg::HI_NOTE_OFF || hi == mrsp_pkg::HI_NOTE_ON ||
          hi == mrsp_pkg::HI_POLY_AT || hi == mrsp_pkg::HI_CTRL ||
          hi == mrsp_pkg::HI_PITCH) begin
        step_res[0] = event_res(run_status[s], held_data[s], b[6:0]);
        step_n = 1;
        add_thru(3, run_status[s], held_data[s], b[6:0], free);
      end
    end
  endtask

  always @(posedge clk) begin : model_and_check
    midi_result_t r;
    midi_result_t got;
    int i;
    if (!rst_n) begin
      thru_off = 1'b0;
      tx_status = '0;
      for (i = 0; i < STREAM_COUNT; i++) begin
        run_status[i] = '0;
        held[i] = 1'b0;
        held_data[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg_wr_en) thru_off = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predict_byte(in_rx_byte, in_stream, in_tx_free);
        if (row_check == ROW_SILENT) begin
          step_n = 0;
        end else if (row_check == ROW_EVENT) begin
          step_res[0] = event_res(row_status, row_d0, row_d1);
          if (step_n == 0) step_n = 1;
        end
        for (i = 0; i < step_n; i++) begin
          r = step_res[i];
          r.last = (i == step_n - 1);
          expected_q.push_back(r);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_status, out_data_first, out_data_second, out_thru_byte,
                out_last};
        if (got.kind == mrsp_pkg::KIND_EVENT) events_seen++;
        else thru_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d status %02h thru %02h",
                 got.kind, got.status, got.thru_byte);
          mismatches++;
        end else begin
          r = expected_q.pop_front();
          if (got.kind !== r.kind) begin
            $error("kind: expected %0d, got %0d", r.kind, got.kind);
            mismatches++;
          end
          if (got.status !== r.status) begin
            $error("status: expected %02h, got %02h", r.status, got.status);
            mismatches++;
          end
          if (got.data_first !== r.data_first) begin
            $error("data_first: expected %02h, got %02h", r.data_first, got.data_first);
            mismatches++;
          end
          if (got.data_second !== r.data_second) begin
            $error("data_second: expected %02h, got %02h", r.data_second, got.data_second);
            mismatches++;
          end
          if (got.thru_byte !== r.thru_byte) begin
            $error("thru_byte: expected %02h, got %02h", r.thru_byte, got.thru_byte);
            mismatches++;
          end
          if (got.last !== r.last) begin
            $error("last: expected %0d, got %0d", r.last, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  // The receiver stalls or takes in runs of random length; each run's kind is random.
  always @(posedge clk) begin : receiver_stall
    logic stall_now;
    if (stall_run == 0) begin
      stall_now = ($urandom_range(0, 2) == 0);
      stall_run = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 24);
      out_stall <= stall_now;
    end
    stall_run--;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without progress", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Sender gaps come between bursts of random length.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s, input logic [6:0] free,
                           input row_check_t check, input logic [7:0] st,
                           input logic [6:0] d0, input logic [6:0] d1);
    pace();
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_stream    <= s;
    in_tx_free   <= free;
    row_check    <= check;
    row_status   <= st;
    row_d0       <= d0;
    row_d1       <= d1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_plain(input logic [7:0] b, input logic s);
    logic [6:0] free;
    case ($urandom_range(0, 3))
      0: free = 7'($urandom_range(0, 3));
      1: free = 7'($urandom_range(60, 127));
      2: free = 7'(TX_SLOTS);
      default: free = 7'($urandom_range(0, 127));
    endcase
    send_byte(b, s, free, ROW_PREDICTED, '0, '0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed messages under running status, with real-time bytes
  // slipped in between data bytes; the rest is noise and broken sequences.
  task automatic send_random_sequence();
    logic       s;
    logic [7:0] st;
    int         pick;
    int         nd;
    int         nmsg;
    s = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_plain(8'($urandom_range(0, 255)), s);
    end else if (pick < 14) begin
      send_plain(8'($urandom_range(mrsp_pkg::SYSCOM_MIN, mrsp_pkg::REALTIME_MIN - 1)), s);
      send_plain(8'($urandom_range(0, 127)), s);
    end else begin
      st = {4'($urandom_range(mrsp_pkg::HI_NOTE_OFF, mrsp_pkg::HI_PITCH)),
            4'($urandom_range(0, 15))};
      if ($urandom_range(0, 9) != 0) send_plain(st, s);
      nd = (st[7:4] == mrsp_pkg::HI_PROGRAM || st[7:4] == mrsp_pkg::HI_CHAN_PRES) ? 1 : 2;
      if ($urandom_range(0, 14) == 0) nd = 3 - nd;
      nmsg = $urandom_range(1, 3);
      repeat (nmsg) begin
        repeat (nd) begin
          if ($urandom_range(0, 9) == 0)
            send_plain(8'($urandom_range(mrsp_pkg::REALTIME_MIN, 8'hFF)), s);
          send_plain(8'($urandom_range(0, 127)), s);
        end
      end
    end
  endtask

  initial begin : stimulus
    int ph;
    int directed_count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].midi, directed_rows[i].strm, directed_rows[i].free,
                directed_rows[i].check, directed_rows[i].st, directed_rows[i].d0,
                directed_rows[i].d1);
    directed_count = bytes_sent;

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= (ph % 2 == 0);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      while (bytes_sent < directed_count + (ph + 1) * RANDOM_ITEMS / PHASES) begin
        send_random_sequence();
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes (%0d from the directed table) with thru on and off.",
             bytes_sent, directed_count);
    $display("Checked %0d events and %0d thru bytes, %0d mismatches.",
             events_seen, thru_seen, mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### midi_running_status_parser_thru_core.f
rtl/mrsp_pkg.sv
rtl/mrsp_front.sv
rtl/mrsp_queue.sv
rtl/mrsp_back.sv
rtl/midi_running_status_parser_thru_core.sv
rtl/mrsp_checker.sv
verif/testbench.sv
